// ===== src/ptshift_pkg.sv =====
// Shared types and constants for the polynomial Taylor shift core.
package ptshift_pkg;

    localparam int DATA_W            = 32;
    localparam int MAX_TERMS_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } ptshift_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } ptshift_mac_res_t;

endpackage

// ===== src/ptshift_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptshift_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ptshift_mac.sv =====
// Shared multiply-add unit: registered product, round, saturate, add, saturate.
module ptshift_mac
    import ptshift_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     mul_en,
    input  logic signed [DATA_W-1:0] shift_value,
    input  logic signed [DATA_W-1:0] operand,
    input  logic signed [DATA_W-1:0] addend,
    input  logic                     addend_flag,
    output ptshift_mac_res_t         res
);

    localparam int PW = 2 * DATA_W;
    localparam logic signed [PW:0] Q_MAX = (PW + 1)'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [PW:0] Q_MIN = -(PW + 1)'(64'sd1 <<< (DATA_W - 1));

    logic signed [PW-1:0]   prod_reg;
    logic signed [PW:0]     rounded;
    logic signed [PW:0]     scaled;
    logic signed [DATA_W-1:0] prod_sat;
    logic                   prod_ovf;
    logic signed [DATA_W:0] sum;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= shift_value * operand;
        end
    end

    always_comb
    begin
        rounded  = {prod_reg[PW-1], prod_reg} + ((PW + 1)'(1) << (FRAC_BITS - 1));
        scaled   = rounded >>> FRAC_BITS;
        prod_ovf = 1'b0;
        if (scaled > Q_MAX)
        begin
            prod_sat = Q_MAX[DATA_W-1:0];
            prod_ovf = 1'b1;
        end
        else if (scaled < Q_MIN)
        begin
            prod_sat = Q_MIN[DATA_W-1:0];
            prod_ovf = 1'b1;
        end
        else
        begin
            prod_sat = scaled[DATA_W-1:0];
        end
        sum = {addend[DATA_W-1], addend} + {prod_sat[DATA_W-1], prod_sat};
        if (sum[DATA_W] != sum[DATA_W-1])
        begin
            res.value = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = sum[DATA_W-1:0];
            res.sat   = addend_flag | prod_ovf;
        end
    end

endmodule

// ===== src/polynomial_taylor_shift_core.sv =====
// Loading: each coefficient is accepted in the cycle it is offered while the core is idle.
// Shift: n(n-1)/2 multiply-adds on the shared MAC, each: RAM read + product register, then add.
// Output: per result a RAM read, then an output register load that waits while out_stall holds.
// Reset (rst_n, async, low) clears control state, term count and shift value to zero.
module polynomial_taylor_shift_core
    import ptshift_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [DATA_W-1:0] shift_value,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] coefficient,
    input  logic                     last_term,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] shifted_coefficient,
    output logic                     last_result,
    output logic                     saturated
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    ptshift_state_t    state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [DATA_W-1:0] carry_reg, carry_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] shift_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_coef_reg, out_coef_next;
    logic              out_last_reg, out_last_next;
    logic              out_sat_reg, out_sat_next;

    logic              in_accept;
    logic              store_ok;
    logic [CW-1:0]     n_new;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W:0]   ram_wdata, ram_rdata;
    logic              mul_en;
    ptshift_mac_res_t  mac_res;
    logic              out_free;

    ptshift_ram #(
        .WIDTH (DATA_W + 1),
        .DEPTH (MAX_TERMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptshift_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk         (clk),
        .mul_en      (mul_en),
        .shift_value (shift_reg),
        .operand     (carry_reg),
        .addend      (ram_rdata[DATA_W-1:0]),
        .addend_flag (ram_rdata[DATA_W]),
        .res         (mac_res)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign store_ok  = (count_reg < CW'(MAX_TERMS));
    assign n_new     = store_ok ? CW'(count_reg + CW'(1)) : count_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                shift_reg <= shift_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        top_reg      <= top_next;
        out_coef_reg <= out_coef_next;
        out_last_reg <= out_last_next;
        out_sat_reg  <= out_sat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        out_coef_next  = out_coef_reg;
        out_last_next  = out_last_reg;
        out_sat_next   = out_sat_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = {1'b0, coefficient};
        ram_re         = 1'b0;
        ram_raddr      = j_reg;
        mul_en         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ram_we = store_ok;
                    if (store_ok)
                    begin
                        top_next = coefficient;
                    end
                    if (last_term)
                    begin
                        count_next = '0;
                        n_next     = n_new;
                        i_next     = '0;
                        k_next     = '0;
                        j_next     = AW'(n_new - CW'(2));
                        carry_next = store_ok ? coefficient : top_reg;
                        state_next = (n_new == CW'(1)) ? ST_EMIT_RD : ST_MUL;
                    end
                    else
                    begin
                        count_next = n_new;
                    end
                end
            end
            ST_MUL:
            begin
                ram_re     = 1'b1;
                ram_raddr  = j_reg;
                mul_en     = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = {mac_res.sat, mac_res.value};
                carry_next = mac_res.value;
                if (j_reg == i_reg)
                begin
                    if ((CW + 1)'(i_reg) + (CW + 1)'(2) >= (CW + 1)'(n_reg))
                    begin
                        k_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        i_next     = AW'(i_reg + AW'(1));
                        j_next     = AW'(n_reg - CW'(2));
                        carry_next = top_reg;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    j_next     = AW'(j_reg - AW'(1));
                    state_next = ST_MUL;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = k_reg;
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = ram_rdata[DATA_W-1:0];
                    out_sat_next   = ram_rdata[DATA_W];
                    out_last_next  = (CW'(k_reg) + CW'(1) == n_reg);
                    if (CW'(k_reg) + CW'(1) == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = AW'(k_reg + AW'(1));
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid           = out_valid_reg;
    assign shifted_coefficient = out_coef_reg;
    assign last_result         = out_last_reg;
    assign saturated           = out_sat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TERMS))
        else $error("term count beyond store depth");

    a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_ADD) |-> (j_reg >= i_reg))
        else $error("inner index below pass index");

    a_top_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (CW'(j_reg) + CW'(1) < n_reg))
        else $error("shift wrote the highest coefficient");

    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT_LOAD))
        else $error("result loaded outside emit phase");

    a_add_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> $past(state_reg == ST_MUL))
        else $error("add without product");

endmodule

// ===== sim/taylor_shift_checker.sv =====
// Watches the core's channels, predicts every shifted coefficient and compares.
module taylor_shift_checker
    import ptshift_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic signed [DATA_W-1:0] shift_value,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [DATA_W-1:0] coefficient,
    input  logic                     last_term,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] shifted_coefficient,
    input  logic                     last_result,
    input  logic                     saturated,
    output int                       fail_count,
    output int                       pending,
    output int                       results_seen,
    output int                       sat_seen
);

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] coef;
        logic                     last;
        logic                     sat;
    } shifted_term_t;

    shifted_term_t            shifted_q[$];
    shifted_term_t            want;
    logic signed [DATA_W-1:0] coef_store [MAX_TERMS];
    logic signed [DATA_W-1:0] shift_v = '0;
    int                       stored = 0;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        sat_seen     = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < 50)
            $display("%0t mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic signed [DATA_W-1:0] clamp_word(input longint x, inout bit hit);
        if (x > WORD_MAX)
        begin
            hit = 1'b1;
            return DATA_W'(WORD_MAX);
        end
        if (x < WORD_MIN)
        begin
            hit = 1'b1;
            return DATA_W'(WORD_MIN);
        end
        return DATA_W'(x);
    endfunction

    // round half up, then clamp
    function automatic logic signed [DATA_W-1:0] fixed_product(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        inout bit hit
    );
        longint p;
        p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_BITS - 1));
        return clamp_word(p >>> FRAC_BITS, hit);
    endfunction

    // repeated synthetic division over the stored coefficients
    function automatic void predict_shift();
        logic signed [DATA_W-1:0] acc [MAX_TERMS];
        bit                       hit [MAX_TERMS];
        logic signed [DATA_W-1:0] prod;
        shifted_term_t            term;
        bit                       f;
        int                       n;
        n = stored;
        for (int i = 0; i < n; i++)
        begin
            acc[i] = coef_store[i];
            hit[i] = 1'b0;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            for (int j = n - 2; j >= i; j--)
            begin
                f = 1'b0;
                prod = fixed_product(shift_v, acc[j+1], f);
                acc[j] = clamp_word(longint'(acc[j]) + longint'(prod), f);
                if (f)
                    hit[j] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            term.coef = acc[i];
            term.last = (i == n - 1);
            term.sat  = hit[i];
            shifted_q.push_back(term);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_v = '0;
            stored  = 0;
            shifted_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shift_v = shift_value;
            if (in_valid && !in_stall)
            begin
                if (stored < MAX_TERMS)
                begin
                    coef_store[stored] = coefficient;
                    stored++;
                end
                if (last_term)
                begin
                    predict_shift();
                    stored = 0;
                end
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (saturated === 1'b1)
                    sat_seen++;
                if (shifted_q.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected",
                                              shifted_coefficient));
                else
                begin
                    want = shifted_q.pop_front();
                    if (shifted_coefficient !== want.coef)
                        report_mismatch($sformatf("shifted_coefficient got %h want %h",
                                                  shifted_coefficient, want.coef));
                    if (last_result !== want.last)
                        report_mismatch($sformatf("last_result got %b want %b",
                                                  last_result, want.last));
                    if (saturated !== want.sat)
                        report_mismatch($sformatf("saturated got %b want %b on %h",
                                                  saturated, want.sat, want.coef));
                end
            end
            pending = shifted_q.size();
        end
    end

endmodule

// ===== sim/polynomial_taylor_shift_core_test.sv =====
// Stimulus and verdict for the polynomial Taylor shift core.
module polynomial_taylor_shift_core_test;
    import ptshift_pkg::*;

    localparam int MAX_TERMS    = MAX_TERMS_DEFAULT;
    localparam int FRAC_BITS    = FRAC_BITS_DEFAULT;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_TERMS * (MAX_TERMS - 1) + 2 * MAX_TERMS + 16;
    localparam int PHASE_ITEMS  = 43;
    localparam int NUM_PHASES   = 7;

    logic                     clk   = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic signed [DATA_W-1:0] shift_value;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] coefficient;
    logic                     last_term;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] shifted_coefficient;
    logic                     last_result;
    logic                     saturated;

    int fail_count;
    int pending;
    int results_seen;
    int sat_seen;
    int cycle_count    = 0;
    int items_sent     = 0;
    int polys_sent     = 0;
    int settings_used  = 0;
    bit hold_off_req   = 1'b0;
    bit out_stall_on   = 1'b1;
    bit in_gaps_on     = 1'b1;

    polynomial_taylor_shift_core #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .shift_value         (shift_value),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .coefficient         (coefficient),
        .last_term           (last_term),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .shifted_coefficient (shifted_coefficient),
        .last_result         (last_result),
        .saturated           (saturated)
    );

    taylor_shift_checker #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .shift_value         (shift_value),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .coefficient         (coefficient),
        .last_term           (last_term),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .shifted_coefficient (shifted_coefficient),
        .last_result         (last_result),
        .saturated           (saturated),
        .fail_count          (fail_count),
        .pending             (pending),
        .results_seen        (results_seen),
        .sat_seen            (sat_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d terms outstanding", cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_coef(input int style);
        case (style)
            0:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            1:       return $urandom();
            default:
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
        endcase
    endfunction

    function automatic int poly_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 85)
            return $urandom_range(7, 12);
        if (r < 95)
            return MAX_TERMS;
        return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
    endfunction

    // receiver side
    initial
    begin
        int stall_len;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (out_stall_on)
            begin
                stall_len = idle_length();
                if (stall_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_coef(input logic [DATA_W-1:0] c, input bit last);
        int gap;
        gap = in_gaps_on ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        coefficient <= c;
        last_term   <= last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_random_poly();
        int n;
        int mode;
        int style;
        n = poly_length();
        mode = $urandom_range(0, 9);
        for (int k = 0; k < n; k++)
        begin
            if (mode < 5)
                style = 0;
            else if (mode < 8)
                style = 1;
            else
                style = $urandom_range(0, 2);
            send_coef(pick_coef(style), k == n - 1);
        end
        polys_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_shift(input logic [DATA_W-1:0] v);
        cfg_valid   <= 1'b1;
        shift_value <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [DATA_W-1:0] phase_shift [NUM_PHASES];
        int                phase_start;
        in_valid    <= 1'b0;
        coefficient <= '0;
        last_term   <= 1'b0;
        cfg_valid   <= 1'b0;
        shift_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shift of zero: terms pass through unchanged
        send_coef(32'h7FFF_FFFF, 1'b1);
        send_coef(32'h0001_0000, 1'b0);
        send_coef(32'hFFFE_0000, 1'b0);
        send_coef(32'h0003_0000, 1'b1);
        polys_sent += 2;
        wait_idle();

        write_shift(32'h0001_0000);
        send_coef(32'h8000_0000, 1'b1);
        send_coef(32'h7FFF_FFFF, 1'b0);
        send_coef(32'h7FFF_FFFF, 1'b1);
        send_coef(32'h8000_0000, 1'b0);
        send_coef(32'h8000_0000, 1'b1);
        // one beyond capacity, dropped though it ends the polynomial
        for (int k = 0; k < MAX_TERMS; k++)
            send_coef(((k % 2) ? 32'h0000_0100 : 32'hFFFF_FF00) + k, 1'b0);
        send_coef(32'h7FFF_FFFF, 1'b1);
        polys_sent += 4;

        phase_shift[0] = 32'h0000_8000;
        phase_shift[1] = 32'hFFFF_0000;
        phase_shift[2] = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
        phase_shift[3] = 32'h7FFF_FFFF;
        phase_shift[4] = 32'h8000_0000;
        phase_shift[5] = 32'h0000_0000;
        phase_shift[6] = $urandom();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_shift(phase_shift[p]);
            in_gaps_on   = !(p == 1 || p == 4);
            out_stall_on = !(p == 4 || p == 5);
            if (p == 2)
                hold_off_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_poly();
        end
        wait_idle();

        $display("Sent %0d coefficients in %0d polynomials under %0d shift settings;",
                 items_sent, polys_sent, settings_used);
        $display("checked %0d shifted terms, %0d of them saturated.", results_seen, sat_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
